/* src/fm_envelope_generator_core_assert.svh */
// assertion macros shared by the envelope generator rtl
`ifndef FM_ENVELOPE_GENERATOR_CORE_ASSERT_SVH
`define FM_ENVELOPE_GENERATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define FMEG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FMEG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FMEG_ASSERT(label, prop, msg)
`define FMEG_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* src/fmeg_pkg.sv */
`default_nettype none

package fmeg_pkg;

    localparam int ATT_W   = 10;
    localparam int CNT_W   = 16;
    localparam int CMD_W   = 2;
    localparam int CODE_W  = 3;
    localparam int STEP_W  = 4;
    localparam int RATE_W  = 6;
    localparam int SHIFT_W = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [ATT_W-1:0] ATT_MAX = 10'd1023;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KEY_ON = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KEY_OFF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_RATE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_RATE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_RATE  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SCALE_SEL = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_NUMBER   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_BLOCK  = 4'd7;

    // phase codes on the result word
    localparam logic [CODE_W-1:0] CODE_OFF     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ATTACK  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DECAY   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd4;

    typedef enum logic [4:0] {
        PH_OFF     = 5'b00001,
        PH_ATTACK  = 5'b00010,
        PH_DECAY   = 5'b00100,
        PH_SUSTAIN = 5'b01000,
        PH_RELEASE = 5'b10000
    } phase_t;

    // increment patterns, bit i is entry i of the row
    localparam logic [7:0] PAT_A   = 8'b0101_0101;
    localparam logic [7:0] PAT_B   = 8'b0101_1101;
    localparam logic [7:0] PAT_C   = 8'b0111_0111;
    localparam logic [7:0] PAT_D   = 8'b0111_1111;
    localparam logic [7:0] PAT_DBL = 8'b0001_0001;

    function automatic logic [CODE_W-1:0] phase_code_of(input phase_t ph);
        logic [CODE_W-1:0] code;
        case (ph)
            PH_ATTACK:  code = CODE_ATTACK;
            PH_DECAY:   code = CODE_DECAY;
            PH_SUSTAIN: code = CODE_SUSTAIN;
            PH_RELEASE: code = CODE_RELEASE;
            default:    code = CODE_OFF;
        endcase
        return code;
    endfunction

    // 64x8 increment table
    function automatic logic [STEP_W-1:0] inc_step(input logic [RATE_W-1:0] rate,
                                                   input logic [2:0] idx);
        logic [STEP_W-1:0] base;
        logic              hit;
        logic [STEP_W-1:0] step;
        base = 4'd0;
        hit  = 1'b0;
        if (rate < 6'd2) begin
            step = 4'd0;
        end else if (rate < 6'd8) begin
            hit  = (rate < 6'd6) ? PAT_A[idx] : PAT_C[idx];
            step = {3'b000, hit};
        end else if (rate < 6'd48) begin
            case (rate[1:0])
                2'd0:    hit = PAT_A[idx];
                2'd1:    hit = PAT_B[idx];
                2'd2:    hit = PAT_C[idx];
                default: hit = PAT_D[idx];
            endcase
            step = {3'b000, hit};
        end else if (rate < 6'd60) begin
            // rows 48..59: base 1, 2 or 4, some entries doubled
            base = 4'd1 << rate[3:2];
            case (rate[1:0])
                2'd0:    hit = 1'b0;
                2'd1:    hit = PAT_DBL[idx];
                2'd2:    hit = PAT_A[idx];
                default: hit = PAT_C[idx];
            endcase
            step = hit ? (base << 1) : base;
        end else begin
            step = 4'd8;
        end
        return step;
    endfunction

endpackage

`default_nettype wire

/* src/fmeg_if.sv */
`default_nettype none

interface fmeg_in_if;
    import fmeg_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CNT_W-1:0]  env_count;
    modport source (output valid, output cmd, output env_count, input ready);
    modport sink   (input valid, input cmd, input env_count, output ready);
endinterface

interface fmeg_out_if;
    import fmeg_pkg::*;
    logic              valid;
    logic              ready;
    logic [ATT_W-1:0]  attenuation_out;
    logic [CODE_W-1:0] phase_code;
    modport source (output valid, output attenuation_out, output phase_code, input ready);
    modport sink   (input valid, input attenuation_out, input phase_code, output ready);
endinterface

interface fmeg_cfg_if;
    import fmeg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/fm_envelope_generator_core.sv */
// result word: registered in the cycle after its input word is taken
// throughput: one word per cycle; state update is a single pass of logic
// from the state registers to the result register, so the output register
// stalls the input only while a result waits and the sink holds ready low
// reset: rst_n async low; config registers to 0, attenuation and held output 1023,
// phase off, key up, result register empty
`default_nettype none
`include "fm_envelope_generator_core_assert.svh"

module fm_envelope_generator_core (
    input  wire logic clk,
    input  wire logic rst_n,
    fmeg_in_if.sink   item,
    fmeg_out_if.source result,
    fmeg_cfg_if.sink  cfg
);
    import fmeg_pkg::*;

    // configuration
    logic [4:0]  attack_rate_reg;
    logic [4:0]  decay_rate_reg;
    logic [4:0]  sustain_rate_reg;
    logic [3:0]  release_rate_reg;
    logic [3:0]  sustain_level_reg;
    logic [1:0]  key_scale_sel_reg;
    logic [10:0] freq_number_reg;
    logic [2:0]  octave_block_reg;

    // envelope state
    logic [ATT_W-1:0] att_reg, att_next;
    phase_t           phase_reg, phase_next;
    logic             key_down_reg, key_down_next;
    logic [ATT_W-1:0] held_reg, held_next;

    // result register
    logic              out_valid_reg;
    logic [ATT_W-1:0]  out_att_reg;
    logic [CODE_W-1:0] out_code_reg;

    logic item_fire;
    logic do_press;
    logic do_release;

    logic                n3;
    logic [4:0]          key_code;
    logic [4:0]          key_scale;
    logic [6:0]          rate_base;
    logic [6:0]          rate_sum;
    logic [RATE_W-1:0]   rate;
    logic [SHIFT_W-1:0]  shift;
    logic [CNT_W-1:0]    low_mask;
    logic [CNT_W-1:0]    count_shr;
    logic                fire;
    logic [STEP_W-1:0]   step;
    logic [ATT_W:0]      att_p1;
    logic [14:0]         prod;
    logic [14:0]         dec;
    logic [ATT_W:0]      att_sum;
    logic [ATT_W-1:0]    sus_thresh;

    assign cfg.ready  = 1'b1;
    assign item.ready = !out_valid_reg || result.ready;
    assign item_fire  = item.valid && item.ready;

    assign result.valid           = out_valid_reg;
    assign result.attenuation_out = out_att_reg;
    assign result.phase_code      = out_code_reg;

    // key code from fnum and block
    assign n3 = (freq_number_reg[10] && (|freq_number_reg[9:7]))
             || (!freq_number_reg[10] && (&freq_number_reg[9:7]));
    assign key_code  = {octave_block_reg, freq_number_reg[10], n3};
    assign key_scale = key_code >> (2'd3 - key_scale_sel_reg);

    always_comb
    begin
        case (phase_reg)
            PH_ATTACK:  rate_base = {1'b0, attack_rate_reg, 1'b0};
            PH_DECAY:   rate_base = {1'b0, decay_rate_reg, 1'b0};
            PH_SUSTAIN: rate_base = {1'b0, sustain_rate_reg, 1'b0};
            default:    rate_base = {1'b0, release_rate_reg, 2'b10};
        endcase
    end

    assign rate_sum  = rate_base + {2'b00, key_scale};
    assign rate      = (rate_sum > 7'd63) ? 6'd63 : rate_sum[RATE_W-1:0];
    assign shift     = (rate < 6'd44) ? (4'd11 - rate[5:2]) : 4'd0;
    assign low_mask  = (16'd1 << shift) - 16'd1;
    assign count_shr = item.env_count >> shift;
    assign fire      = (item.env_count & low_mask) == '0;
    assign step      = inc_step(rate, count_shr[2:0]);

    // attack: att -= ceil((att + 1) * step / 16)
    assign att_p1     = {1'b0, att_reg} + 11'd1;
    assign prod       = 15'(att_p1) * 15'(step);
    assign dec        = (prod + 15'd15) >> 4;
    assign att_sum    = {1'b0, att_reg} + 11'(step);
    assign sus_thresh = {sustain_level_reg, 6'b0};

    assign do_press   = (item.cmd == CMD_KEY_ON || (item.cmd == CMD_TOGGLE && !key_down_reg))
                     && !key_down_reg;
    assign do_release = (item.cmd == CMD_KEY_OFF || (item.cmd == CMD_TOGGLE && key_down_reg))
                     && key_down_reg;

    always_comb
    begin
        att_next      = att_reg;
        phase_next    = phase_reg;
        key_down_next = key_down_reg;
        held_next     = held_reg;
        if (item.cmd == CMD_TICK) begin
            if (phase_reg != PH_OFF) begin
                if (fire) begin
                    case (phase_reg)
                        PH_ATTACK:
                        begin
                            if (dec >= 15'(att_reg)) begin
                                att_next   = '0;
                                phase_next = PH_DECAY;
                            end else begin
                                att_next = att_reg - dec[ATT_W-1:0];
                            end
                        end
                        PH_DECAY:
                        begin
                            att_next = (att_sum > 11'(ATT_MAX)) ? ATT_MAX : att_sum[ATT_W-1:0];
                            if (att_next >= sus_thresh) begin
                                phase_next = PH_SUSTAIN;
                            end
                        end
                        default:
                        begin
                            if (att_sum >= 11'(ATT_MAX)) begin
                                att_next   = ATT_MAX;
                                phase_next = PH_OFF;
                            end else begin
                                att_next = att_sum[ATT_W-1:0];
                            end
                        end
                    endcase
                end
                if (phase_next != PH_OFF) begin
                    held_next = att_next;
                end
            end
        end else if (do_press) begin
            phase_next    = PH_ATTACK;
            att_next      = ATT_MAX;
            key_down_next = 1'b1;
        end else if (do_release) begin
            phase_next    = PH_RELEASE;
            key_down_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            attack_rate_reg   <= '0;
            decay_rate_reg    <= '0;
            sustain_rate_reg  <= '0;
            release_rate_reg  <= '0;
            sustain_level_reg <= '0;
            key_scale_sel_reg <= '0;
            freq_number_reg   <= '0;
            octave_block_reg  <= '0;
        end else if (cfg.valid && cfg.ready) begin
            case (cfg.index)
                CFG_ATTACK_RATE:   attack_rate_reg   <= cfg.data[4:0];
                CFG_DECAY_RATE:    decay_rate_reg    <= cfg.data[4:0];
                CFG_SUSTAIN_RATE:  sustain_rate_reg  <= cfg.data[4:0];
                CFG_RELEASE_RATE:  release_rate_reg  <= cfg.data[3:0];
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg.data[3:0];
                CFG_KEY_SCALE_SEL: key_scale_sel_reg <= cfg.data[1:0];
                CFG_FREQ_NUMBER:   freq_number_reg   <= cfg.data[10:0];
                CFG_OCTAVE_BLOCK:  octave_block_reg  <= cfg.data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            att_reg       <= ATT_MAX;
            phase_reg     <= PH_OFF;
            key_down_reg  <= 1'b0;
            held_reg      <= ATT_MAX;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_fire) begin
                att_reg       <= att_next;
                phase_reg     <= phase_next;
                key_down_reg  <= key_down_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each word
    always_ff @(posedge clk)
    begin
        if (item_fire) begin
            out_att_reg  <= held_next;
            out_code_reg <= phase_code_of(phase_next);
        end
    end

    `FMEG_ASSERT(a_press_starts_attack,
        item_fire && item.cmd == CMD_KEY_ON && !key_down_reg
            |=> phase_reg == PH_ATTACK && att_reg == ATT_MAX,
        "key on did not restart attack")
    `FMEG_ASSERT(a_key_up_phase,
        !key_down_reg |-> (phase_reg == PH_OFF || phase_reg == PH_RELEASE),
        "key up while in attack, decay or sustain")
    `FMEG_ASSERT(a_held_only_on_tick,
        !(item_fire && item.cmd == CMD_TICK) |=> $stable(held_reg),
        "held output changed without a tick")
    `FMEG_ASSERT_ALWAYS(a_stall_blocks_input,
        out_valid_reg && !result.ready |-> !item.ready,
        "input taken while result word stalled")

endmodule

`default_nettype wire
